// ----- src/lpfm_pkg.sv -----
// Shared types and constants for the linked page FIFO manager.
package lpfm_pkg;

  localparam int OP_W      = 2;
  localparam int PAGE_W    = 10;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_REM  = 2'd2,
    OP_WALK = 2'd3
  } lpfm_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_MEMBER_ERR = 2'd2
  } lpfm_status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINK
  } lpfm_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr;     // clear one membership entry
    logic accept;  // capture transaction and read link stores
    logic exec;    // apply operation and load result register
    logic link;    // back-link old head to newly enqueued page
  } lpfm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;   // clearing pass is at its last entry
    logic out_free;   // result register can take a new result
    logic need_link;  // current enqueue needs the back-link write
  } lpfm_sts_t;

endpackage

// ----- src/linked_page_fifo_manager.sv -----
// Top level of the linked page FIFO manager: controller plus datapath.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_ready | opcode, page_index, from_tail
//   output  | out_valid/out_ready | page_out, page_found, status, entry_count
//
// From acceptance to the next acceptance an operation runs through these steps:
// accept with link store read, then execute with store writes and back to idle.
// Enqueue onto a non-empty list adds a link step for the second write to the
// previous link store, which has a single write port.
// After reset a clearing pass over every entry zeroes the membership store;
// in_ready stays low throughout it.
// A full result register stalls the execute step until out_ready frees it.
module linked_page_fifo_manager #(
  parameter int PAGE_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lpfm_pkg::OP_W-1:0]       opcode,
  input  logic [lpfm_pkg::PAGE_W-1:0]     page_index,
  input  logic                            from_tail,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpfm_pkg::PAGE_W-1:0]     page_out,
  output logic                            page_found,
  output logic [lpfm_pkg::STAT_W-1:0]     status,
  output logic [lpfm_pkg::CNT_OUT_W-1:0]  entry_count
);
  import lpfm_pkg::*;

  lpfm_cmd_t cmd;
  lpfm_sts_t sts;

  // Sequence the operation
  lpfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Hold stores and list state
  lpfm_dpath #(
    .PAGE_SLOTS (PAGE_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .page_index  (page_index),
    .from_tail   (from_tail),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .page_out    (page_out),
    .page_found  (page_found),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

// ----- src/lpfm_ctrl.sv -----
// Controller state machine for the linked page FIFO manager.
module lpfm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output lpfm_pkg::lpfm_cmd_t cmd,
  input  lpfm_pkg::lpfm_sts_t sts
);
  import lpfm_pkg::*;

  lpfm_state_t state;
  lpfm_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = sts.need_link ? S_LINK : S_IDLE;
        end
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- src/lpfm_dpath.sv -----
// Datapath for the linked page FIFO manager: link stores, list registers, result register.
module lpfm_dpath #(
  parameter int PAGE_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lpfm_pkg::lpfm_cmd_t             cmd,
  output lpfm_pkg::lpfm_sts_t             sts,
  input  logic [lpfm_pkg::OP_W-1:0]       opcode,
  input  logic [lpfm_pkg::PAGE_W-1:0]     page_index,
  input  logic                            from_tail,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpfm_pkg::PAGE_W-1:0]     page_out,
  output logic                            page_found,
  output logic [lpfm_pkg::STAT_W-1:0]     status,
  output logic [lpfm_pkg::CNT_OUT_W-1:0]  entry_count
);
  import lpfm_pkg::*;

  localparam int SLOT_W = $clog2(PAGE_SLOTS);
  localparam int LINK_W = SLOT_W + 1;
  localparam int CNT_W  = $clog2(PAGE_SLOTS + 1);
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(PAGE_SLOTS);

  // Link and membership stores
  logic [LINK_W-1:0] next_mem [PAGE_SLOTS];
  logic [LINK_W-1:0] prev_mem [PAGE_SLOTS];
  logic              in_mem   [PAGE_SLOTS];

  // List registers
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] clr_addr;
  logic [SLOT_W-1:0] link_addr;

  // Captured transaction
  lpfm_op_t          op_q;
  logic [PAGE_W-1:0] page_q;
  logic              from_tail_q;
  logic              in_range_q;

  // Registered read data
  logic [LINK_W-1:0] next_rd;
  logic [LINK_W-1:0] prev_rd;
  logic              in_rd;

  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] p_slot;
  logic              cnt_zero;
  logic              member;
  logic              nx_ok;
  logic              pr_ok;

  // Operation results
  logic [SLOT_W-1:0] head_next;
  logic [SLOT_W-1:0] tail_next;
  logic [CNT_W-1:0]  count_next;
  logic [SLOT_W-1:0] res_page;
  logic              res_found;
  lpfm_status_t      res_status;
  logic              need_link;

  // Store write ports before command gating
  logic              next_we;
  logic [SLOT_W-1:0] next_wa;
  logic [LINK_W-1:0] next_wd;
  logic              prev_we;
  logic [SLOT_W-1:0] prev_wa;
  logic [LINK_W-1:0] prev_wd;
  logic              in_we;
  logic [SLOT_W-1:0] in_wa;
  logic              in_wd;

  // Store write ports after command gating
  logic              next_we_f;
  logic              prev_we_f;
  logic [SLOT_W-1:0] prev_wa_f;
  logic [LINK_W-1:0] prev_wd_f;
  logic              in_we_f;
  logic [SLOT_W-1:0] in_wa_f;
  logic              in_wd_f;

  // Result register
  logic [SLOT_W-1:0] page_out_q;
  logic              page_found_q;
  lpfm_status_t      status_q;
  logic [CNT_W-1:0]  count_out_q;

  // Read address: dequeue reads at the tail, everything else at the page
  always_comb begin
    if (lpfm_op_t'(opcode) == OP_DEQ) begin
      rd_addr = tail;
    end else begin
      rd_addr = SLOT_W'(page_index);
    end
  end

  assign p_slot   = SLOT_W'(page_q);
  assign cnt_zero = (count == '0);
  assign member   = in_range_q && in_rd;
  assign nx_ok    = (next_rd < NO_LINK);
  assign pr_ok    = (prev_rd < NO_LINK);

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q        <= lpfm_op_t'(opcode);
      page_q      <= page_index;
      from_tail_q <= from_tail;
      in_range_q  <= (32'(page_index) < PAGE_SLOTS);
    end
  end

  // Apply the operation
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    res_page   = '0;
    res_found  = 1'b0;
    res_status = ST_OK;
    need_link  = 1'b0;
    next_we    = 1'b0;
    next_wa    = p_slot;
    next_wd    = NO_LINK;
    prev_we    = 1'b0;
    prev_wa    = p_slot;
    prev_wd    = NO_LINK;
    in_we      = 1'b0;
    in_wa      = p_slot;
    in_wd      = 1'b0;
    case (op_q)
      OP_ENQ: begin
        if (!in_range_q || in_rd) begin
          res_status = ST_MEMBER_ERR;
        end else begin
          next_we    = 1'b1;
          next_wd    = cnt_zero ? NO_LINK : LINK_W'(head);
          prev_we    = 1'b1;
          in_we      = 1'b1;
          in_wd      = 1'b1;
          head_next  = p_slot;
          if (cnt_zero) begin
            tail_next = p_slot;
          end
          count_next = count + CNT_W'(1);
          need_link  = !cnt_zero;
        end
      end
      OP_DEQ: begin
        if (cnt_zero) begin
          res_status = ST_EMPTY;
        end else begin
          res_page  = tail;
          res_found = 1'b1;
          if (pr_ok) begin
            next_we   = 1'b1;
            next_wa   = prev_rd[SLOT_W-1:0];
            tail_next = prev_rd[SLOT_W-1:0];
          end else begin
            head_next = '0;
            tail_next = '0;
          end
          in_we      = 1'b1;
          in_wa      = tail;
          count_next = count - CNT_W'(1);
        end
      end
      OP_REM: begin
        if (cnt_zero) begin
          res_status = ST_EMPTY;
        end else if (!member) begin
          res_status = ST_MEMBER_ERR;
        end else begin
          if (head == p_slot) begin
            head_next = nx_ok ? next_rd[SLOT_W-1:0] : '0;
          end
          if (tail == p_slot) begin
            tail_next = pr_ok ? prev_rd[SLOT_W-1:0] : '0;
          end
          if (nx_ok) begin
            prev_we = 1'b1;
            prev_wa = next_rd[SLOT_W-1:0];
            prev_wd = prev_rd;
          end
          if (pr_ok) begin
            next_we = 1'b1;
            next_wa = prev_rd[SLOT_W-1:0];
            next_wd = next_rd;
          end
          in_we      = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      OP_WALK: begin
        if (from_tail_q) begin
          if (!cnt_zero) begin
            res_page  = tail;
            res_found = 1'b1;
          end
        end else if (!member) begin
          res_status = ST_MEMBER_ERR;
        end else if (pr_ok) begin
          res_page  = prev_rd[SLOT_W-1:0];
          res_found = 1'b1;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Gate store writes by command
  always_comb begin
    next_we_f = cmd.exec && next_we;
    prev_we_f = (cmd.exec && prev_we) || cmd.link;
    prev_wa_f = cmd.link ? link_addr : prev_wa;
    prev_wd_f = cmd.link ? LINK_W'(p_slot) : prev_wd;
    in_we_f   = cmd.clr || (cmd.exec && in_we);
    in_wa_f   = cmd.clr ? clr_addr : in_wa;
    in_wd_f   = cmd.clr ? 1'b0 : in_wd;
  end

  // Next link store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      next_rd <= next_mem[rd_addr];
    end
    if (next_we_f) begin
      next_mem[next_wa] <= next_wd;
    end
  end

  // Previous link store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prev_rd <= prev_mem[rd_addr];
    end
    if (prev_we_f) begin
      prev_mem[prev_wa_f] <= prev_wd_f;
    end
  end

  // Membership store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_rd <= in_mem[rd_addr];
    end
    if (in_we_f) begin
      in_mem[in_wa_f] <= in_wd_f;
    end
  end

  // List registers and clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (cmd.exec) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // Hold old head for the back-link write
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      link_addr <= head;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      page_out_q   <= res_page;
      page_found_q <= res_found;
      status_q     <= res_status;
      count_out_q  <= count_next;
    end
  end

  assign page_out    = PAGE_W'(page_out_q);
  assign page_found  = page_found_q;
  assign status      = status_q;
  assign entry_count = CNT_OUT_W'(count_out_q);

  // Status to controller
  assign sts.clr_last  = (clr_addr == SLOT_W'(PAGE_SLOTS - 1));
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.need_link = need_link;

`ifndef ASSERT_OFF
  a_link_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.link |-> $past(cmd.exec))
    else $error("back-link write without preceding execute");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.exec))
    else $error("result appeared without an execute");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (count == $past(count) || count == $past(count) + 1 ||
                  count == $past(count) - 1))
    else $error("entry count moved by more than one");
`endif

endmodule
